### sv/sync_len_xor_frame_receiver_defines.svh
// Assertion macros for the frame receiver modules; slxfr_outbuf uses them.
`ifndef SYNC_LEN_XOR_FRAME_RECEIVER_DEFINES_SVH
`define SYNC_LEN_XOR_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SLXFR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame receiver check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SLXFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame receiver check failed");

`endif

### sv/slxfr_pkg.sv
// Types and constants of the sync, length and XOR checksum frame receiver.
`timescale 1ns / 1ps

package slxfr_pkg;

  localparam logic [7:0] FRAME_PAYLOAD_LEN = 8'd2;
  localparam logic [7:0] SYNC_RESET        = 8'hAA;
  localparam int unsigned OUT_TDATA_W      = 24;

  typedef enum logic [4:0] {
    PH_HUNT = 5'b00001,
    PH_SYNC = 5'b00010,
    PH_LEN  = 5'b00100,
    PH_B0   = 5'b01000,
    PH_B1   = 5'b10000
  } phase_t;

  typedef struct packed {
    logic       frame_status;
    logic [7:0] press_code;
    logic [7:0] btn_code;
  } result_t;

endpackage

### sv/slxfr_parser.sv
// Frame parser: phase register, held payload bytes and checksum compare.
`timescale 1ns / 1ps

module slxfr_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_valid,
  input  logic [7:0]          rx_byte,
  input  logic                flush,
  input  logic [7:0]          sync_value,
  output logic                res_valid,
  output slxfr_pkg::result_t  res_data
);

  slxfr_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] held_button_r, held_button_nxt;
  logic [7:0] held_click_r, held_click_nxt;
  slxfr_pkg::phase_t hunt_phase;

  assign hunt_phase = (rx_byte == sync_value) ? slxfr_pkg::PH_SYNC : slxfr_pkg::PH_HUNT;

  always_comb begin
    phase_nxt       = phase_r;
    held_button_nxt = held_button_r;
    held_click_nxt  = held_click_r;
    res_valid       = 1'b0;
    if (byte_valid) begin
      if (flush) begin
        phase_nxt = slxfr_pkg::PH_HUNT;
      end else begin
        unique case (phase_r)
          slxfr_pkg::PH_SYNC: begin
            phase_nxt = (rx_byte == slxfr_pkg::FRAME_PAYLOAD_LEN) ?
                        slxfr_pkg::PH_LEN : hunt_phase;
          end
          slxfr_pkg::PH_LEN: begin
            held_button_nxt = rx_byte;
            phase_nxt       = slxfr_pkg::PH_B0;
          end
          slxfr_pkg::PH_B0: begin
            held_click_nxt = rx_byte;
            phase_nxt      = slxfr_pkg::PH_B1;
          end
          slxfr_pkg::PH_B1: begin
            res_valid = 1'b1;
            phase_nxt = slxfr_pkg::PH_HUNT;
          end
          default: begin
            phase_nxt = hunt_phase;
          end
        endcase
      end
    end
  end

  assign res_data.btn_code     = held_button_r;
  assign res_data.press_code   = held_click_r;
  assign res_data.frame_status = ((held_button_r ^ held_click_r) != rx_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= slxfr_pkg::PH_HUNT;
      held_button_r <= 8'd0;
      held_click_r  <= 8'd0;
    end else begin
      phase_r       <= phase_nxt;
      held_button_r <= held_button_nxt;
      held_click_r  <= held_click_nxt;
    end
  end

endmodule

### sv/slxfr_outbuf.sv
// Result register with a skid stage between the parser and the result channel.
`timescale 1ns / 1ps

`include "sync_len_xor_frame_receiver_defines.svh"

module slxfr_outbuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  slxfr_pkg::result_t  push_data,
  output logic                ready,
  output logic                out_valid,
  input  logic                out_ready,
  output slxfr_pkg::result_t  out_data
);

  logic               out_valid_r, out_valid_nxt;
  logic               skid_valid_r, skid_valid_nxt;
  slxfr_pkg::result_t out_data_r, out_data_nxt;
  slxfr_pkg::result_t skid_data_r, skid_data_nxt;

  assign ready     = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        out_data_nxt  = push_data;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  `SLXFR_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r)
  `SLXFR_ASSERT_NOW(a_no_push_when_full, push, !skid_valid_r)
  `SLXFR_ASSERT_NEXT(a_stalled_push_to_skid, out_valid_r && !out_ready && push, skid_valid_r)

endmodule

### sv/sync_len_xor_frame_receiver.sv
// Top level of the sync, length and XOR checksum frame receiver.
//
// Channel   Direction  Payload
// in_*      in         tdata: rx_byte; tuser: flush
// out_*     out        tdata: btn_code, press_code, frame_status
// cfg_*     in         data: sync_value
//
// One byte is accepted per cycle while in_tready is high; a completed frame's
// result is registered into the result register, or the skid stage on a stall.
// The result register and its skid stage hold two results, so input stalls
// only once both are occupied by results that the sink has not taken.
// Reset returns the parser to hunting, empties the output stages and sets
// the sync value to 8'hAA.
`timescale 1ns / 1ps

module sync_len_xor_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [0:0]  in_tuser,   // [0] flush
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [slxfr_pkg::OUT_TDATA_W-1:0] out_tdata,  // [7:0] btn_code,
                                  // [15:8] press_code, [16] frame_status, [23:17] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data    // [7:0] sync_value
);

  logic [7:0]         sync_value_r;
  logic               byte_valid;
  logic               buf_ready;
  logic               res_valid;
  slxfr_pkg::result_t res_data;
  slxfr_pkg::result_t out_data;

  assign cfg_ready  = 1'b1;
  assign in_tready  = buf_ready;
  assign byte_valid = in_tvalid && buf_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_value_r <= slxfr_pkg::SYNC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      sync_value_r <= cfg_data;
    end
  end

  slxfr_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .rx_byte    (in_tdata),
    .flush      (in_tuser[0]),
    .sync_value (sync_value_r),
    .res_valid  (res_valid),
    .res_data   (res_data)
  );

  slxfr_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res_data),
    .ready     (buf_ready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_data)
  );

  assign out_tdata = {7'd0, out_data};

endmodule
